// ----- src/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and codes for the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // item kinds on the input channel
    typedef enum logic [0:0] {
        KIND_START = 1'b0,
        KIND_RESP  = 1'b1
    } item_kind_t;

    // result kinds on the output channel
    typedef enum logic [0:0] {
        RES_REQUEST = 1'b0,
        RES_DONE    = 1'b1
    } result_kind_t;

    // walk completion status
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_BOUND       = 2'd2
    } walk_status_t;

    // page size codes
    typedef enum logic [1:0] {
        PS_4K = 2'd0,
        PS_2M = 2'd1,
        PS_1G = 2'd2
    } page_size_t;

    // level codes
    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_1G   = 2'd1;
    localparam logic [1:0] LVL_2M   = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    // entry bit positions
    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_LARGE   = 7;

    // widths
    localparam int unsigned PA_W    = 52;
    localparam int unsigned VA_W    = 48;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned PAGE_SH = 12;
    localparam int unsigned BOUND_SH = 32;

    // walk state carried between transactions
    typedef struct packed {
        logic              busy;
        logic [1:0]        level;
        logic [PA_W-1:0]   table_addr;
        logic [VA_W-1:0]   saved_virt;
    } walk_state_t;

    // one result item
    typedef struct packed {
        result_kind_t      result_kind;
        logic [DATA_W-1:0] read_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [1:0]        level;
        page_size_t        page_size_code;
        logic [DATA_W-1:0] leaf_entry;
        walk_status_t      status;
    } walk_result_t;

endpackage

// ----- src/ptw_step.sv -----
// ----------------------------------------------------------------------------
// ptw_step
// Combinational walk step: next walk state and the result of one transaction.
// ----------------------------------------------------------------------------
module ptw_step (
    input  ptw_pkg::walk_state_t        state,
    input  logic [63:0]                 window_base,
    input  ptw_pkg::item_kind_t         kind,
    input  logic [51:0]                 root_table,
    input  logic [47:0]                 virt_addr,
    input  logic [63:0]                 entry_data,
    output ptw_pkg::walk_state_t        state_next,
    output logic                        emit,
    output ptw_pkg::walk_result_t       result
);
    import ptw_pkg::*;

    walk_state_t        req_state;
    logic [IDX_W-1:0]   idx;
    logic               beyond_bound;
    logic [PA_W-1:0]    entry_table;

    // table selected for the next request, before the bound check
    always_comb
    begin
        req_state   = state;
        entry_table = {entry_data[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
        if (kind == KIND_START)
        begin
            req_state.busy       = 1'b1;
            req_state.level      = LVL_TOP;
            req_state.table_addr = {root_table[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
            req_state.saved_virt = virt_addr;
        end
        else
        begin
            req_state.table_addr = entry_table;
            req_state.level      = state.level + 2'd1;
        end
    end

    // index slice of the virtual address for the requested level
    always_comb
    begin
        unique case (req_state.level)
            LVL_TOP:  idx = req_state.saved_virt[47:39];
            LVL_1G:   idx = req_state.saved_virt[38:30];
            LVL_2M:   idx = req_state.saved_virt[29:21];
            default:  idx = req_state.saved_virt[20:12];
        endcase
    end

    assign beyond_bound = |req_state.table_addr[PA_W-1:BOUND_SH];

    // decide the outcome of this transaction
    always_comb
    begin
        state_next            = state;
        emit                  = 1'b1;
        result.result_kind    = RES_DONE;
        result.read_addr      = '0;
        result.phys_addr      = '0;
        result.level          = state.level;
        result.page_size_code = PS_4K;
        result.leaf_entry     = '0;
        result.status         = ST_OK;

        if (kind == KIND_RESP && !state.busy)
        begin
            // stray response, dropped
            emit = 1'b0;
        end
        else if (kind == KIND_RESP && !entry_data[BIT_PRESENT])
        begin
            state_next.busy   = 1'b0;
            result.leaf_entry = entry_data;
            result.status     = ST_NOT_PRESENT;
        end
        else if (kind == KIND_RESP && state.level == LVL_LEAF)
        begin
            state_next.busy   = 1'b0;
            result.leaf_entry = entry_data;
            result.phys_addr  = {entry_data[51:12], state.saved_virt[11:0]};
        end
        else if (kind == KIND_RESP && state.level == LVL_1G && entry_data[BIT_LARGE])
        begin
            state_next.busy       = 1'b0;
            result.leaf_entry     = entry_data;
            result.page_size_code = PS_1G;
            result.phys_addr      = {entry_data[51:30], state.saved_virt[29:0]};
        end
        else if (kind == KIND_RESP && state.level == LVL_2M && entry_data[BIT_LARGE])
        begin
            state_next.busy       = 1'b0;
            result.leaf_entry     = entry_data;
            result.page_size_code = PS_2M;
            result.phys_addr      = {entry_data[51:21], state.saved_virt[20:0]};
        end
        else if (beyond_bound)
        begin
            // next table out of reach, walk ends at the new level
            state_next        = req_state;
            state_next.busy   = 1'b0;
            result.level      = req_state.level;
            result.status     = ST_BOUND;
        end
        else
        begin
            state_next         = req_state;
            result.result_kind = RES_REQUEST;
            result.level       = LVL_TOP;
            result.read_addr   = window_base + {12'd0,
                                 req_state.table_addr[PA_W-1:PAGE_SH], idx, 3'b000};
        end
    end

endmodule

// ----- src/page_table_walker_top.sv -----
// ----------------------------------------------------------------------------
// page_table_walker_top
// Four-level x86-64 page table walker driven by start and read-response items.
// ----------------------------------------------------------------------------
// Each input transaction produces at most one result: a start gives a read
// request (or an immediate bound fault), and each response gives the next read
// request or the finished walk. A new transaction is taken every cycle while
// the result register is empty or being drained; a valid result appears in the
// cycle after acceptance, held in the single result register behind the step
// logic. Responses with no walk in flight are consumed silently. window_base
// may be written only while the block is idle.
module page_table_walker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [51:0] root_table,
    input  logic [47:0] virt_addr,
    input  logic [63:0] entry_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [63:0] read_addr,
    output logic [51:0] phys_addr,
    output logic [1:0]  level,
    output logic [1:0]  page_size_code,
    output logic [63:0] leaf_entry,
    output logic [1:0]  status
);
    import ptw_pkg::*;

    logic [63:0]  window_base_reg;
    walk_state_t  state_reg;
    walk_state_t  state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    walk_result_t result_reg;
    walk_result_t step_result;
    logic         step_emit;
    logic         in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // walk step
    ptw_step u_step (
        .state       (state_reg),
        .window_base (window_base_reg),
        .kind        (item_kind_t'(kind)),
        .root_table  (root_table),
        .virt_addr   (virt_addr),
        .entry_data  (entry_data),
        .state_next  (state_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    // output valid next value
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (in_fire && step_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= '0;
            state_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_base_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (in_fire && step_emit)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = result_reg.result_kind;
    assign read_addr      = result_reg.read_addr;
    assign phys_addr      = result_reg.phys_addr;
    assign level          = result_reg.level;
    assign page_size_code = result_reg.page_size_code;
    assign leaf_entry     = result_reg.leaf_entry;
    assign status         = result_reg.status;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level page table walker. A stimulus
// process queues start and read-response transactions, most of them
// well-formed walks with random entries and some noise. A driver feeds them to
// the block and predicts each result at acceptance. A monitor compares every
// result with the oldest prediction. The window base is rewritten before each
// set of walks, and in the first two phases sender and receiver stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import ptw_pkg::*;

    localparam int unsigned TOP_SHIFT      = 39;
    localparam int unsigned ITEMS_PER_SET  = 290;
    localparam int unsigned SETS_PER_PHASE = 2;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned END_CYCLES     = 20;
    localparam int unsigned STALL_LIMIT    = 2000;

    // one queued input transaction
    typedef struct {
        item_kind_t  kind;
        logic [51:0] root;
        logic [47:0] virt;
        logic [63:0] entry;
    } walk_item_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [63:0] cfg_wdata      = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic        kind           = 1'b0;
    logic [51:0] root_table     = '0;
    logic [47:0] virt_addr      = '0;
    logic [63:0] entry_data     = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        result_kind;
    logic [63:0] read_addr;
    logic [51:0] phys_addr;
    logic [1:0]  level;
    logic [1:0]  page_size_code;
    logic [63:0] leaf_entry;
    logic [1:0]  status;

    // stimulus and checking state
    walk_item_t   walk_items[$];
    walk_result_t walk_results_due[$];
    walk_result_t step_result;
    logic         step_has_result = 1'b0;
    int unsigned  send_idle_pct   = 12;
    int unsigned  recv_idle_pct   = 65;
    int unsigned  mismatch_count  = 0;
    int unsigned  stall_cycles    = 0;

    // predictor copy of the walk state and window base
    logic         walk_active = 1'b0;
    logic [1:0]   walk_lvl    = LVL_TOP;
    logic [51:0]  walk_table  = '0;
    logic [47:0]  walk_virt   = '0;
    logic [63:0]  window_copy = '0;

    page_table_walker_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .root_table     (root_table),
        .virt_addr      (virt_addr),
        .entry_data     (entry_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .read_addr      (read_addr),
        .phys_addr      (phys_addr),
        .level          (level),
        .page_size_code (page_size_code),
        .leaf_entry     (leaf_entry),
        .status         (status)
    );

    // clock
    always #5 clk = ~clk;

    // read request for the entry indexed at the current level
    function automatic walk_result_t entry_request();
        walk_result_t r;
        int unsigned  sh;
        logic [8:0]   idx;
        r = '0;
        r.result_kind = RES_REQUEST;
        sh = TOP_SHIFT - IDX_W * walk_lvl;
        idx = 9'((walk_virt >> sh) & 48'h1FF);
        r.read_addr = window_copy + 64'(walk_table) + 64'({idx, 3'b000});
        return r;
    endfunction

    // finished walk, success or fault
    function automatic walk_result_t walk_done(input logic [63:0] ent,
                                               input walk_status_t st,
                                               input page_size_t ps,
                                               input logic [51:0] pa);
        walk_result_t r;
        r = '0;
        r.result_kind    = RES_DONE;
        r.phys_addr      = pa;
        r.level          = walk_lvl;
        r.page_size_code = ps;
        r.leaf_entry     = ent;
        r.status         = st;
        walk_active = 1'b0;
        return r;
    endfunction

    // advance the walk by one transaction, returns 1 when a result follows
    function automatic bit predict_walk(input item_kind_t k, input logic [51:0] root,
                                        input logic [47:0] va, input logic [63:0] ent,
                                        output walk_result_t res);
        page_size_t  ps;
        logic [51:0] pm;
        res = '0;
        if (k == KIND_START) begin
            walk_table  = {root[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
            walk_virt   = va;
            walk_lvl    = LVL_TOP;
            walk_active = 1'b1;
            if (walk_table[PA_W-1:BOUND_SH] != '0)
                res = walk_done(64'h0, ST_BOUND, PS_4K, '0);
            else
                res = entry_request();
            return 1'b1;
        end
        if (!walk_active)
            return 1'b0;
        if (!ent[BIT_PRESENT]) begin
            res = walk_done(ent, ST_NOT_PRESENT, PS_4K, '0);
        end
        else if (walk_lvl == LVL_LEAF ||
                 (ent[BIT_LARGE] && (walk_lvl == LVL_1G || walk_lvl == LVL_2M))) begin
            unique case (walk_lvl)
                LVL_1G:
                begin
                    ps = PS_1G;
                    pm = 52'h3FFF_FFFF;
                end
                LVL_2M:
                begin
                    ps = PS_2M;
                    pm = 52'h1F_FFFF;
                end
                default:
                begin
                    ps = PS_4K;
                    pm = 52'hFFF;
                end
            endcase
            res = walk_done(ent, ST_OK, ps,
                            ({ent[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}} & ~pm)
                            + ({4'h0, walk_virt} & pm));
        end
        else begin
            walk_table = {ent[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
            walk_lvl   = walk_lvl + 2'd1;
            if (walk_table[PA_W-1:BOUND_SH] != '0)
                res = walk_done(64'h0, ST_BOUND, PS_4K, '0);
            else
                res = entry_request();
        end
        return 1'b1;
    endfunction

    // window base copy follows the register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_copy <= '0;
        else if (cfg_we)
            window_copy <= cfg_wdata;
    end

    // driver: predict on acceptance, then present the next transaction
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        walk_result_t res;
        bit           has_res;
        walk_item_t   it;
        if (!rst_n) begin
            in_valid        <= 1'b0;
            step_has_result <= 1'b0;
            walk_active = 1'b0;
            walk_lvl    = LVL_TOP;
            walk_table  = '0;
            walk_virt   = '0;
        end
        else begin
            has_res = 1'b0;
            res = '0;
            if (in_valid && in_ready)
                has_res = predict_walk(item_kind_t'(kind), root_table, virt_addr,
                                       entry_data, res);
            step_has_result <= has_res;
            step_result     <= res;
            if (!in_valid || in_ready) begin
                if (walk_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = walk_items.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= it.kind;
                    root_table <= it.root;
                    virt_addr  <= it.virt;
                    entry_data <= it.entry;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // field compare
    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", field, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: store predictions, check each result transaction
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        walk_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (step_has_result)
                walk_results_due.push_back(step_result);
            if (out_valid && out_ready) begin
                if (walk_results_due.size() == 0) begin
                    $error("result with no prediction waiting: kind %0d addr %h",
                           result_kind, read_addr);
                    mismatch_count++;
                end
                else begin
                    want = walk_results_due.pop_front();
                    check_field("result_kind", want.result_kind, result_kind);
                    check_field("read_addr", want.read_addr, read_addr);
                    check_field("phys_addr", want.phys_addr, phys_addr);
                    check_field("level", want.level, level);
                    check_field("page_size_code", want.page_size_code, page_size_code);
                    check_field("leaf_entry", want.leaf_entry, leaf_entry);
                    check_field("status", want.status, status);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_item(input item_kind_t k, input logic [51:0] root,
                             input logic [47:0] va, input logic [63:0] ent);
        walk_item_t it;
        it.kind  = k;
        it.root  = root;
        it.virt  = va;
        it.entry = ent;
        walk_items.push_back(it);
    endtask

    // wait until every transaction is in and every result is out
    task automatic wait_idle();
        do
            @(negedge clk);
        while (walk_items.size() != 0 || in_valid || step_has_result ||
               walk_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // random walks with random entries, plus aborted walks and stray transactions
    task automatic queue_random_walks(input int unsigned target);
        int unsigned made;
        int unsigned pick;
        int unsigned r;
        logic [1:0]  lvl;
        logic [51:0] root;
        logic [63:0] ent;
        bit          walking;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                if ($urandom_range(9) == 0)
                    root = 52'({$urandom, $urandom});
                else
                    root = {20'h0, 32'($urandom)};
                push_item(KIND_START, root, 48'({$urandom, $urandom}),
                          {$urandom, $urandom});
                made++;
                walking = (root[PA_W-1:BOUND_SH] == '0);
                lvl = LVL_TOP;
                while (walking) begin
                    if ($urandom_range(99) < 4)
                        break;
                    ent = {$urandom, $urandom};
                    r = $urandom_range(99);
                    if (r < 7) begin
                        ent[BIT_PRESENT] = 1'b0;
                        walking = 1'b0;
                    end
                    else begin
                        ent[BIT_PRESENT] = 1'b1;
                        if (lvl == LVL_LEAF) begin
                            walking = 1'b0;
                        end
                        else if (r < 12) begin
                            ent[PA_W-1:BOUND_SH] = 20'($urandom_range(20'hFFFFF, 1));
                            if (lvl != LVL_TOP)
                                ent[BIT_LARGE] = 1'b0;
                            walking = 1'b0;
                        end
                        else if (lvl != LVL_TOP && r < 35) begin
                            ent[BIT_LARGE] = 1'b1;
                            walking = 1'b0;
                        end
                        else begin
                            ent[PA_W-1:BOUND_SH] = '0;
                            if (lvl != LVL_TOP)
                                ent[BIT_LARGE] = 1'b0;
                            lvl = lvl + 2'd1;
                        end
                    end
                    push_item(KIND_RESP, 52'({$urandom, $urandom}),
                              48'({$urandom, $urandom}), ent);
                    made++;
                end
            end
            else if (pick < 93) begin
                push_item(KIND_RESP, 52'({$urandom, $urandom}),
                          48'({$urandom, $urandom}), {$urandom, $urandom});
                made++;
            end
            else begin
                push_item(item_kind_t'($urandom_range(1)), 52'({$urandom, $urandom}),
                          48'({$urandom, $urandom}), {$urandom, $urandom});
                made++;
            end
        end
    endtask

    // stimulus sequence and final verdict
    initial
    begin
        logic [63:0] base;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_window(64'h0);

        // root beyond the bound, all ones and exactly at the bound
        push_item(KIND_START, 52'hF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0);
        push_item(KIND_START, 52'h0_0001_0000_0000, 48'h0, '0);
        // full walk at the highest indexes down to a 4 KiB leaf
        push_item(KIND_START, 52'h0_0000_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0);
        push_item(KIND_RESP, '0, '0, 64'hFFF0_0000_FFFF_FFFF);
        push_item(KIND_RESP, '0, '0, 64'hFFF0_0000_FFFF_FF7F);
        push_item(KIND_RESP, '0, '0, 64'hFFF0_0000_FFFF_FF7F);
        push_item(KIND_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        // 1 GiB page
        push_item(KIND_START, '0, '0, '0);
        push_item(KIND_RESP, '0, '0, 64'h1);
        push_item(KIND_RESP, '0, '0, 64'h0000_0000_4000_0081);
        // 2 MiB page
        push_item(KIND_START, 52'h1000, 48'h8000_0020_0123, '0);
        push_item(KIND_RESP, '0, '0, 64'h2001);
        push_item(KIND_RESP, '0, '0, 64'h3001);
        push_item(KIND_RESP, '0, '0, 64'h8000_0000_0060_0081);
        // entry not present at the top
        push_item(KIND_START, '0, 48'h1234_5678_9ABC, '0);
        push_item(KIND_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        // next table at the bound
        push_item(KIND_START, '0, '0, '0);
        push_item(KIND_RESP, '0, '0, 64'h0000_0001_0000_0001);
        // new start drops the walk in flight
        push_item(KIND_START, '0, 48'h0000_0000_1000, '0);
        push_item(KIND_RESP, '0, '0, 64'h1);
        push_item(KIND_START, 52'h5000, 48'hFFFF_0000_0000, '0);
        push_item(KIND_RESP, '0, '0, 64'h0);
        // response with no walk in flight
        push_item(KIND_RESP, '0, '0, 64'h1);
        wait_idle();

        // three stall profiles, each over two window bases
        for (int phase = 0; phase < 3; phase++) begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int set = 0; set < SETS_PER_PHASE; set++) begin
                unique case (phase * SETS_PER_PHASE + set)
                    0:       base = 64'hFFFF_FFFF_FFFF_FFFF;
                    2:       base = 64'h0;
                    4:       base = 64'hFFFF_FFFF_0000_0000;
                    default: base = {$urandom, $urandom};
                endcase
                write_window(base);
                queue_random_walks(ITEMS_PER_SET);
                wait_idle();
            end
        end

        repeat (END_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
